// ===== src/pfcseq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfcseq_pkg
// Shared types, register indexes and constants of the PFC power sequencer.
// ----------------------------------------------------------------------------
package pfcseq_pkg;

    localparam int ADC_BITS  = 12;
    localparam int CNT_BITS  = 16;
    localparam int CFG_BITS  = 16;
    localparam int CFG_IDX_BITS = 3;

    localparam int RAMP_STEPS_DEFAULT         = 16;
    localparam int RELAY_SETTLE_TICKS_DEFAULT = 100;

    localparam logic [CNT_BITS-1:0] CNT_MAX = '1;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_BROWN_IN_LEVEL  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BROWN_OUT_LEVEL = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BROWN_IN_DELAY  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BROWN_OUT_DELAY = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RELAY_ON_DELAY  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RELAY_OFF_DELAY = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TARGET_VOLTAGE  = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RAMP_INTERVAL   = 3'd7;

    typedef struct packed {
        logic [ADC_BITS-1:0] brown_in_level;
        logic [ADC_BITS-1:0] brown_out_level;
        logic [CNT_BITS-1:0] brown_in_delay;
        logic [CNT_BITS-1:0] brown_out_delay;
        logic [CNT_BITS-1:0] relay_on_delay;
        logic [CNT_BITS-1:0] relay_off_delay;
        logic [ADC_BITS-1:0] target_voltage;
        logic [CNT_BITS-1:0] ramp_interval;
    } cfg_t;

    typedef struct packed {
        logic [ADC_BITS-1:0] vac_rms;
        logic [ADC_BITS-1:0] bulk_voltage;
        logic                at_zero_cross;
        logic                fault;
    } in_item_t;

    typedef struct packed {
        logic [2:0]          seq_state;
        logic                input_ok;
        logic                relay_on;
        logic [ADC_BITS-1:0] voltage_ref;
        logic                regulating;
        logic                pwm_off;
        logic                comp_reset;
    } out_item_t;

    // sequencer requests to the soft-start unit
    typedef struct packed {
        logic step;     // run one ramp step this tick
        logic standby;  // standby actions: disarm ramp, drop regulation
        logic off;      // off state: drop regulation
    } ramp_ctrl_t;

    function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] c);
        sat_inc = (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

endpackage

// ===== src/pfcseq_qualifier.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfcseq_qualifier
// Brown-in / brown-out qualifier with good and bad tick counters.
// ----------------------------------------------------------------------------
module pfcseq_qualifier
    import pfcseq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  cfg_t                cfg,
    input  logic [ADC_BITS-1:0] vac_rms,
    output logic                input_ok_next
);

    logic [CNT_BITS-1:0] good_count_reg, good_count_next;
    logic [CNT_BITS-1:0] bad_count_reg,  bad_count_next;
    logic                input_ok_reg;

    always_comb
    begin
        good_count_next = good_count_reg;
        bad_count_next  = bad_count_reg;
        input_ok_next   = input_ok_reg;
        if (vac_rms > cfg.brown_in_level)
        begin
            bad_count_next = '0;
            if (good_count_reg > cfg.brown_in_delay)
                input_ok_next = 1'b1;
            else
                good_count_next = sat_inc(good_count_reg);
        end
        else if (vac_rms < cfg.brown_out_level)
        begin
            good_count_next = '0;
            if (bad_count_reg > cfg.brown_out_delay)
                input_ok_next = 1'b0;
            else
                bad_count_next = sat_inc(bad_count_reg);
        end
        else
        begin
            // level between thresholds
            good_count_next = '0;
            bad_count_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            good_count_reg <= '0;
            bad_count_reg  <= '0;
            input_ok_reg   <= 1'b0;
        end
        else if (advance)
        begin
            good_count_reg <= good_count_next;
            bad_count_reg  <= bad_count_next;
            input_ok_reg   <= input_ok_next;
        end
    end

endmodule

// ===== src/pfcseq_relay.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfcseq_relay
// Inrush relay drive with on and off delay counters.
// ----------------------------------------------------------------------------
module pfcseq_relay
    import pfcseq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic advance,
    input  cfg_t cfg,
    input  logic input_ok,
    output logic relay_on_next
);

    logic [CNT_BITS-1:0] on_count_reg,  on_count_next;
    logic [CNT_BITS-1:0] off_count_reg, off_count_next;
    logic                relay_reg;

    always_comb
    begin
        on_count_next  = on_count_reg;
        off_count_next = off_count_reg;
        relay_on_next  = relay_reg;
        if (input_ok)
        begin
            off_count_next = '0;
            if (on_count_reg > cfg.relay_on_delay)
                relay_on_next = 1'b1;
            else
                on_count_next = sat_inc(on_count_reg);
        end
        else
        begin
            on_count_next = '0;
            if (off_count_reg > cfg.relay_off_delay)
                relay_on_next = 1'b0;
            else
                off_count_next = sat_inc(off_count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_count_reg  <= '0;
            off_count_reg <= '0;
            relay_reg     <= 1'b0;
        end
        else if (advance)
        begin
            on_count_reg  <= on_count_next;
            off_count_reg <= off_count_next;
            relay_reg     <= relay_on_next;
        end
    end

endmodule

// ===== src/pfcseq_ramp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfcseq_ramp
// Soft-start reference ramp and regulation flag.
// ----------------------------------------------------------------------------
module pfcseq_ramp
    import pfcseq_pkg::*;
#(
    parameter int RAMP_STEPS = RAMP_STEPS_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  cfg_t                cfg,
    input  ramp_ctrl_t          ctrl,
    input  logic [ADC_BITS-1:0] bulk_voltage,
    output logic                regulating,
    output logic [ADC_BITS-1:0] voltage_ref_next,
    output logic                regulating_next
);

    // divide by RAMP_STEPS as multiply by a rounded-up reciprocal
    localparam int RECIP_SHIFT = ADC_BITS + $clog2(RAMP_STEPS);
    localparam longint RECIP_VAL = ((64'd1 << RECIP_SHIFT) + RAMP_STEPS - 1) / RAMP_STEPS;
    localparam int RECIP_BITS = RECIP_SHIFT + 1;
    localparam int PROD_BITS = ADC_BITS + RECIP_BITS;
    localparam logic [RECIP_BITS-1:0] RECIP = RECIP_BITS'(RECIP_VAL);

    logic                armed_reg,  armed_next;
    logic [ADC_BITS-1:0] step_reg,   step_next;
    logic [CNT_BITS-1:0] timer_reg,  timer_next;
    logic [ADC_BITS-1:0] ref_reg;
    logic                regulation_reg;

    logic [ADC_BITS-1:0]  diff;
    logic [PROD_BITS-1:0] prod;
    logic [ADC_BITS-1:0]  quot;
    logic [ADC_BITS:0]    ref_base;
    logic [ADC_BITS:0]    ref_sum;
    logic [CNT_BITS:0]    timer_inc;

    assign regulating = regulation_reg;

    assign diff = (cfg.target_voltage > bulk_voltage) ?
                  (cfg.target_voltage - bulk_voltage) : '0;
    assign prod = PROD_BITS'(diff) * PROD_BITS'(RECIP);
    assign quot = prod[RECIP_SHIFT +: ADC_BITS];

    always_comb
    begin
        armed_next       = armed_reg;
        step_next        = step_reg;
        timer_next       = timer_reg;
        voltage_ref_next = ref_reg;
        regulating_next  = regulation_reg;
        ref_base         = {1'b0, ref_reg};
        ref_sum          = '0;
        timer_inc        = '0;
        if (ctrl.standby)
        begin
            armed_next      = 1'b0;
            regulating_next = 1'b0;
        end
        else if (ctrl.off)
        begin
            regulating_next = 1'b0;
        end
        else if (ctrl.step)
        begin
            // first tick of a ramp latches the start from the bulk voltage
            if (!armed_reg)
            begin
                armed_next = 1'b1;
                step_next  = quot;
                ref_base   = {1'b0, bulk_voltage} + {1'b0, quot};
                timer_inc  = {(CNT_BITS+1){1'b0}} + 1'b1;
            end
            else
            begin
                timer_inc = {1'b0, timer_reg} + 1'b1;
            end
            ref_sum = ref_base;
            if (timer_inc >= {1'b0, cfg.ramp_interval})
            begin
                timer_next = '0;
                if (ref_base <= {1'b0, cfg.target_voltage})
                    ref_sum = ref_base + {1'b0, step_next};
            end
            else
            begin
                timer_next = timer_inc[CNT_BITS-1:0];
            end
            if (ref_sum >= {1'b0, cfg.target_voltage} || bulk_voltage >= cfg.target_voltage)
            begin
                voltage_ref_next = cfg.target_voltage;
                regulating_next  = 1'b1;
            end
            else
            begin
                voltage_ref_next = ref_sum[ADC_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg      <= 1'b0;
            step_reg       <= '0;
            timer_reg      <= '0;
            ref_reg        <= '0;
            regulation_reg <= 1'b0;
        end
        else if (advance)
        begin
            armed_reg      <= armed_next;
            step_reg       <= step_next;
            timer_reg      <= timer_next;
            ref_reg        <= voltage_ref_next;
            regulation_reg <= regulating_next;
        end
    end

endmodule

// ===== src/pfc_power_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_power_sequencer
// Brown-in qualification, inrush relay control and soft-start sequencing.
// ----------------------------------------------------------------------------
// One input transfer is one control tick. The block registers the result of
// each tick in an output register, presenting it in the cycle after the tick;
// a tick is taken whenever the output register is empty or its result is
// being taken in the same cycle, so the sustained rate is one tick per clock
// while out_ready stays high. All tick work (qualifier, relay delays, state
// machine and one ramp step) is a single short combinational pass ahead of
// the state and output registers; the only multiplier divides the soft-start
// span by the ramp step count via a constant reciprocal. There is no memory
// and no clearing pass after reset. Configuration registers are written with
// cfg_we, cfg_index and cfg_data and must only be changed while no tick is
// in flight. The off state is sticky until reset.
// ----------------------------------------------------------------------------
module pfc_power_sequencer
    import pfcseq_pkg::*;
#(
    parameter int RAMP_STEPS         = RAMP_STEPS_DEFAULT,
    parameter int RELAY_SETTLE_TICKS = RELAY_SETTLE_TICKS_DEFAULT
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // configuration write port
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]     cfg_data,
    // tick input
    input  logic                    in_valid,
    output logic                    in_ready,
    input  in_item_t                in_item,
    // result output
    output logic                    out_valid,
    input  logic                    out_ready,
    output out_item_t               out_item
);

    // sequencer states
    localparam logic [2:0] M_INIT       = 3'd0;
    localparam logic [2:0] M_STANDBY    = 3'd1;
    localparam logic [2:0] M_RELAY_WAIT = 3'd2;
    localparam logic [2:0] M_SOFT_START = 3'd3;
    localparam logic [2:0] M_NORMAL     = 3'd4;
    localparam logic [2:0] M_OFF        = 3'd5;

    localparam logic [CNT_BITS-1:0] SETTLE = CNT_BITS'(RELAY_SETTLE_TICKS);

    cfg_t                cfg_reg;
    logic [2:0]          mode_reg, mode_next;
    logic [CNT_BITS-1:0] wait_reg, wait_next;
    logic                out_valid_reg;
    out_item_t           out_item_reg;

    logic                advance;
    logic                input_ok_next;
    logic                relay_on_next;
    logic                regulating;
    logic                regulating_next;
    logic [ADC_BITS-1:0] voltage_ref_next;
    logic                pwm_off;
    logic                comp_reset;
    ramp_ctrl_t          ramp_ctrl;

    // a tick moves on when the result register is free or being emptied
    assign in_ready  = !out_valid_reg || out_ready;
    assign advance   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.brown_in_level  <= ADC_BITS'(2000);
            cfg_reg.brown_out_level <= ADC_BITS'(1800);
            cfg_reg.brown_in_delay  <= CNT_BITS'(100);
            cfg_reg.brown_out_delay <= CNT_BITS'(100);
            cfg_reg.relay_on_delay  <= CNT_BITS'(500);
            cfg_reg.relay_off_delay <= CNT_BITS'(10);
            cfg_reg.target_voltage  <= ADC_BITS'(3500);
            cfg_reg.ramp_interval   <= CNT_BITS'(10);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BROWN_IN_LEVEL:  cfg_reg.brown_in_level  <= cfg_data[ADC_BITS-1:0];
                CFG_BROWN_OUT_LEVEL: cfg_reg.brown_out_level <= cfg_data[ADC_BITS-1:0];
                CFG_BROWN_IN_DELAY:  cfg_reg.brown_in_delay  <= cfg_data;
                CFG_BROWN_OUT_DELAY: cfg_reg.brown_out_delay <= cfg_data;
                CFG_RELAY_ON_DELAY:  cfg_reg.relay_on_delay  <= cfg_data;
                CFG_RELAY_OFF_DELAY: cfg_reg.relay_off_delay <= cfg_data;
                CFG_TARGET_VOLTAGE:  cfg_reg.target_voltage  <= cfg_data[ADC_BITS-1:0];
                CFG_RAMP_INTERVAL:   cfg_reg.ramp_interval   <= cfg_data;
                default:             cfg_reg <= cfg_reg;
            endcase
        end
    end

    // step 1: brown-in / brown-out qualifier
    pfcseq_qualifier u_qualifier (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .cfg           (cfg_reg),
        .vac_rms       (in_item.vac_rms),
        .input_ok_next (input_ok_next)
    );

    // step 2: relay delays work on the freshly qualified status
    pfcseq_relay u_relay (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .cfg           (cfg_reg),
        .input_ok      (input_ok_next),
        .relay_on_next (relay_on_next)
    );

    // step 3: sequencer state machine
    always_comb
    begin
        mode_next  = mode_reg;
        wait_next  = wait_reg;
        pwm_off    = 1'b0;
        comp_reset = 1'b0;
        ramp_ctrl  = '0;
        case (mode_reg)
            M_INIT:
            begin
                mode_next = M_STANDBY;
            end
            M_STANDBY:
            begin
                if (in_item.fault)
                    mode_next = M_OFF;
                else if (input_ok_next)
                    mode_next = M_RELAY_WAIT;
                wait_next         = '0;
                pwm_off           = 1'b1;
                comp_reset        = 1'b1;
                ramp_ctrl.standby = 1'b1;
            end
            M_RELAY_WAIT:
            begin
                // only the relay, settle time and zero cross matter here
                if (relay_on_next)
                begin
                    if (wait_reg > SETTLE)
                    begin
                        if (in_item.at_zero_cross)
                            mode_next = M_SOFT_START;
                    end
                    else
                    begin
                        wait_next = sat_inc(wait_reg);
                    end
                end
            end
            M_SOFT_START:
            begin
                if (in_item.fault)
                    mode_next = M_OFF;
                else if (!input_ok_next)
                    mode_next = M_STANDBY;
                else if (regulating)
                    mode_next = M_NORMAL;
            end
            M_NORMAL:
            begin
                if (in_item.fault)
                    mode_next = M_OFF;
                else if (!input_ok_next)
                    mode_next = M_STANDBY;
            end
            default:
            begin
                // off, and any unused code, lands in off
                mode_next     = M_OFF;
                pwm_off       = 1'b1;
                ramp_ctrl.off = 1'b1;
            end
        endcase
        // step 4: ramp runs whenever the tick ends in soft start
        ramp_ctrl.step = (mode_next == M_SOFT_START);
    end

    pfcseq_ramp #(
        .RAMP_STEPS (RAMP_STEPS)
    ) u_ramp (
        .clk              (clk),
        .rst_n            (rst_n),
        .advance          (advance),
        .cfg              (cfg_reg),
        .ctrl             (ramp_ctrl),
        .bulk_voltage     (in_item.bulk_voltage),
        .regulating       (regulating),
        .voltage_ref_next (voltage_ref_next),
        .regulating_next  (regulating_next)
    );

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_INIT;
            wait_reg <= '0;
        end
        else if (advance)
        begin
            mode_reg <= mode_next;
            wait_reg <= wait_next;
        end
    end

    // result register: valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // result register: payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg.seq_state   <= mode_next;
            out_item_reg.input_ok    <= input_ok_next;
            out_item_reg.relay_on    <= relay_on_next;
            out_item_reg.voltage_ref <= voltage_ref_next;
            out_item_reg.regulating  <= regulating_next;
            out_item_reg.pwm_off     <= pwm_off;
            out_item_reg.comp_reset  <= comp_reset;
        end
    end

    // off is sticky
    a_off_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == M_OFF |=> mode_reg == M_OFF)
        else $error("sequencer left the off state");

    // soft start is only reached from relay wait or itself
    a_soft_start_entry: assert property (@(posedge clk) disable iff (!rst_n)
        advance && mode_next == M_SOFT_START |->
            (mode_reg == M_RELAY_WAIT || mode_reg == M_SOFT_START))
        else $error("soft start entered from a wrong state");

    // every taken tick yields a result in the next cycle
    a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("tick transfer produced no result");

    // compensator reset only comes with pwm forced off
    a_comp_reset_pwm: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.comp_reset |-> out_item_reg.pwm_off)
        else $error("compensator reset without pwm off");

    // at most one ramp request per tick
    a_ramp_ctrl_excl: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(ramp_ctrl) <= 1)
        else $error("conflicting ramp requests");

endmodule
